// ===== hdl/pia_pkg.sv =====
// pia_pkg: shared constants, widths, codes and state type for the process id allocator
// no dependencies; used by process_id_allocator_core
`default_nettype none

package pia_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ID_LIMIT    = 1024;

   localparam int SLOT_W   = $clog2(TABLE_DEPTH);
   localparam int ISSUE_W  = SLOT_W + 1;
   localparam int ID_W     = $clog2(ID_LIMIT);
   localparam int LAST_W   = ID_W + 1;
   localparam int CNT_W    = 7;
   localparam int LIMIT_W  = 7;
   localparam int STATUS_W = 2;
   localparam int RST_W    = $clog2(2 * ID_LIMIT + 2);

   // most live ids the table and the id space can ever hold
   localparam int TABLE_CAP = (TABLE_DEPTH < ID_LIMIT - 1) ? TABLE_DEPTH : ID_LIMIT - 1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic             REG_PROCESS_LIMIT = 1'b0;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 7'd64;

   localparam logic REQ_ALLOC   = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FREE,
      ST_REL,
      ST_PUT
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/process_id_allocator_core.sv =====
// process_id_allocator_core: allocates and releases process ids from a slot table
// depends on pia_pkg; the id table is a synchronous memory with a registered read
`default_nettype none

// channel   direction  handshake              payload
// req       in         req_valid/req_ready    req_type, req_release_pid
// rsp       out        rsp_valid/rsp_ready    rsp_pid, rsp_status, rsp_live_count
// csr       in/out     apb psel/penable       process_limit at byte address 0
//
// release: one table read per cycle, from slot zero until a match or the last slot
// allocate: the free-slot walk over the valid flops, after a table rescan when the next
//   id reaches the bound; a full table or a reached limit answers without either
// the block returns to idle when the result is registered
// slot valid bits are flops cleared by reset, so the table is usable right after reset
// a finished result waits in the output register while the next transaction is taken

module process_id_allocator_core (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire                                req_type,
   input  wire  [pia_pkg::ID_W-1:0]           req_release_pid,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [pia_pkg::ID_W-1:0]           rsp_pid,
   output logic [pia_pkg::STATUS_W-1:0]       rsp_status,
   output logic [pia_pkg::CNT_W-1:0]          rsp_live_count,
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire  [pia_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire  [pia_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pia_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int SLOT_W  = pia_pkg::SLOT_W;
   localparam int ISSUE_W = pia_pkg::ISSUE_W;
   localparam int ID_W    = pia_pkg::ID_W;
   localparam int LAST_W  = pia_pkg::LAST_W;
   localparam int CNT_W   = pia_pkg::CNT_W;
   localparam int LIMIT_W = pia_pkg::LIMIT_W;
   localparam int STAT_W  = pia_pkg::STATUS_W;
   localparam int RST_W   = pia_pkg::RST_W;
   localparam int DEPTH   = pia_pkg::TABLE_DEPTH;

   pia_pkg::state_type state_ff, state_in;

   logic [LAST_W-1:0]  last_ff, last_in;
   logic [LAST_W-1:0]  safe_ff, safe_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [DEPTH-1:0]   slot_valid_ff, slot_valid_in;
   logic [ID_W-1:0]    rel_ff, rel_in;
   logic [ISSUE_W-1:0] issue_ff, issue_in;
   logic               pend_ff, pend_in;
   logic [SLOT_W-1:0]  rd_slot_ff, rd_slot_in;
   logic [ID_W-1:0]    rd_data_ff;
   logic [RST_W-1:0]   restarts_ff, restarts_in;
   logic [SLOT_W-1:0]  free_ff, free_in;
   logic [ID_W-1:0]    res_pid_ff, res_pid_in;
   logic [STAT_W-1:0]  res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]    rsp_pid_ff, rsp_pid_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic [ID_W-1:0]    id_mem [DEPTH];
   logic [SLOT_W-1:0]  rd_addr;
   logic               mem_we;

   logic               accept;
   logic               scanning;
   logic               issue_en;
   logic               slot_live;
   logic [LAST_W-1:0]  id_ext;
   logic               id_hit;
   logic [LAST_W-1:0]  last_inc;
   logic [LAST_W-1:0]  last_wrap;
   logic               need_restart;
   logic [RST_W-1:0]   restarts_inc;
   logic               runaway;
   logic               scan_last;
   logic               scan_done;
   logic               rel_hit;
   logic               rel_miss;
   logic               free_hit;
   logic               out_free;
   logic               alloc_full;
   logic               alloc_rescan;
   logic               csr_write;

   // ---------------------------------------------------------------- evaluation
   always_comb begin
      accept       = req_valid && req_ready;
      scanning     = (state_ff == pia_pkg::ST_SCAN) || (state_ff == pia_pkg::ST_REL);
      issue_en     = issue_ff < ISSUE_W'(DEPTH);
      slot_live    = pend_ff && slot_valid_ff[rd_slot_ff];
      id_ext       = {1'b0, rd_data_ff};
      id_hit       = slot_live && (id_ext == last_ff);
      last_inc     = last_ff + LAST_W'(1);
      last_wrap    = (last_inc >= LAST_W'(pia_pkg::ID_LIMIT)) ? LAST_W'(1) : last_inc;
      need_restart = (state_ff == pia_pkg::ST_SCAN) && id_hit && (last_inc >= safe_ff);
      restarts_inc = restarts_ff + RST_W'(1);
      runaway      = need_restart && (restarts_inc > RST_W'(2 * pia_pkg::ID_LIMIT));
      scan_last    = pend_ff && (rd_slot_ff == SLOT_W'(DEPTH - 1));
      scan_done    = (state_ff == pia_pkg::ST_SCAN) && !need_restart && scan_last;
      rel_hit      = (state_ff == pia_pkg::ST_REL) && slot_live && (rd_data_ff == rel_ff);
      rel_miss     = (state_ff == pia_pkg::ST_REL) && !rel_hit && scan_last;
      free_hit     = (state_ff == pia_pkg::ST_FREE) && !slot_valid_ff[free_ff];
      out_free     = !rsp_valid_ff || rsp_ready;
      alloc_full   = (count_ff >= limit_ff) || (count_ff >= CNT_W'(pia_pkg::TABLE_CAP));
      alloc_rescan = (last_inc >= safe_ff) || (last_inc >= LAST_W'(pia_pkg::ID_LIMIT));
      // restart goes back to slot zero in the same cycle, dropping the read in flight
      rd_addr      = need_restart ? '0 : issue_ff[SLOT_W-1:0];
      csr_write    = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                     (csr_paddr[2] == pia_pkg::REG_PROCESS_LIMIT);
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pia_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_type == pia_pkg::REQ_RELEASE) begin
                  state_in = pia_pkg::ST_REL;
               end else if (alloc_full) begin
                  state_in = pia_pkg::ST_PUT;
               end else if (alloc_rescan) begin
                  state_in = pia_pkg::ST_SCAN;
               end else begin
                  state_in = pia_pkg::ST_FREE;
               end
            end
         end
         pia_pkg::ST_SCAN: begin
            if (runaway) begin
               state_in = pia_pkg::ST_PUT;
            end else if (scan_done) begin
               state_in = pia_pkg::ST_FREE;
            end
         end
         pia_pkg::ST_FREE: begin
            if (free_hit) begin
               state_in = pia_pkg::ST_PUT;
            end
         end
         pia_pkg::ST_REL: begin
            if (rel_hit || rel_miss) begin
               state_in = pia_pkg::ST_PUT;
            end
         end
         pia_pkg::ST_PUT: begin
            if (out_free) begin
               state_in = pia_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pia_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- outputs and datapath
   always_comb begin
      req_ready     = (state_ff == pia_pkg::ST_IDLE);
      last_in       = last_ff;
      safe_in       = safe_ff;
      count_in      = count_ff;
      slot_valid_in = slot_valid_ff;
      rel_in        = rel_ff;
      restarts_in   = restarts_ff;
      free_in       = free_ff;
      res_pid_in    = res_pid_ff;
      res_status_in = res_status_ff;
      mem_we        = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_pid_in    = rsp_pid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      limit_in      = csr_write ? csr_pwdata[LIMIT_W-1:0] : limit_ff;

      // table read pipeline, one slot per cycle
      if (scanning) begin
         pend_in    = need_restart || issue_en;
         rd_slot_in = rd_addr;
         issue_in   = need_restart ? ISSUE_W'(1) : issue_ff + ISSUE_W'(issue_en);
      end else begin
         pend_in    = 1'b0;
         rd_slot_in = rd_slot_ff;
         issue_in   = '0;
      end

      case (state_ff)
         pia_pkg::ST_IDLE: begin
            free_in = '0;
            if (accept) begin
               res_pid_in = '0;
               if (req_type == pia_pkg::REQ_RELEASE) begin
                  rel_in        = req_release_pid;
                  res_status_in = pia_pkg::STATUS_NOT_FOUND;
               end else if (alloc_full) begin
                  res_status_in = pia_pkg::STATUS_FULL;
               end else begin
                  last_in       = last_wrap;
                  res_status_in = pia_pkg::STATUS_OK;
                  if (alloc_rescan) begin
                     safe_in     = LAST_W'(pia_pkg::ID_LIMIT);
                     restarts_in = '0;
                  end
               end
            end
         end
         pia_pkg::ST_SCAN: begin
            if (id_hit) begin
               if (need_restart) begin
                  last_in     = last_wrap;
                  safe_in     = LAST_W'(pia_pkg::ID_LIMIT);
                  restarts_in = restarts_inc;
                  if (runaway) begin
                     res_status_in = pia_pkg::STATUS_FULL;
                  end
               end else begin
                  last_in = last_inc;
               end
            end else if (slot_live && (id_ext > last_ff) && (safe_ff > id_ext)) begin
               safe_in = id_ext;
            end
         end
         pia_pkg::ST_FREE: begin
            if (free_hit) begin
               mem_we                 = 1'b1;
               slot_valid_in[free_ff] = 1'b1;
               count_in               = count_ff + CNT_W'(1);
               res_pid_in             = last_ff[ID_W-1:0];
               res_status_in          = pia_pkg::STATUS_OK;
            end else begin
               free_in = free_ff + SLOT_W'(1);
            end
         end
         pia_pkg::ST_REL: begin
            if (rel_hit) begin
               slot_valid_in[rd_slot_ff] = 1'b0;
               count_in                  = count_ff - CNT_W'(1);
               res_pid_in                = rel_ff;
               res_status_in             = pia_pkg::STATUS_OK;
            end
         end
         pia_pkg::ST_PUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_pid_in    = res_pid_ff;
               rsp_status_in = res_status_ff;
               rsp_count_in  = count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pid        = rsp_pid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_live_count = rsp_count_ff;
   assign csr_pready     = 1'b1;
   assign csr_prdata     = (csr_paddr[2] == pia_pkg::REG_PROCESS_LIMIT) ?
                           {{(pia_pkg::CSR_DATA_W - LIMIT_W){1'b0}}, limit_ff} : '0;

   // ---------------------------------------------------------------- id memory
   // writes happen only in the free-slot walk, never while a scan reads
   always_ff @(posedge clock) begin
      if (mem_we) begin
         id_mem[free_ff] <= last_ff[ID_W-1:0];
      end
      rd_data_ff <= id_mem[rd_addr];
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pia_pkg::ST_IDLE;
         last_ff       <= LAST_W'(pia_pkg::ID_LIMIT);
         safe_ff       <= LAST_W'(pia_pkg::ID_LIMIT);
         count_ff      <= '0;
         limit_ff      <= pia_pkg::LIMIT_RESET;
         slot_valid_ff <= '0;
         issue_ff      <= '0;
         pend_ff       <= 1'b0;
         restarts_ff   <= '0;
         free_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_ff       <= last_in;
         safe_ff       <= safe_in;
         count_ff      <= count_in;
         limit_ff      <= limit_in;
         slot_valid_ff <= slot_valid_in;
         issue_ff      <= issue_in;
         pend_ff       <= pend_in;
         restarts_ff   <= restarts_in;
         free_ff       <= free_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rel_ff        <= rel_in;
      rd_slot_ff    <= rd_slot_in;
      res_pid_ff    <= res_pid_in;
      res_status_ff <= res_status_in;
      rsp_pid_ff    <= rsp_pid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule

`default_nettype wire

// ===== verif/process_id_allocator_checker.sv =====
// process_id_allocator_checker: tracks the live id table, predicts each transaction's outcome
// and compares it with the block's results and the limit readback; depends on pia_pkg
`timescale 1ns / 1ps

module process_id_allocator_checker (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   input  wire                               req_ready,
   input  wire                               req_type,
   input  wire  [pia_pkg::ID_W-1:0]          req_release_pid,
   input  wire                               rsp_valid,
   input  wire                               rsp_ready,
   input  wire  [pia_pkg::ID_W-1:0]          rsp_pid,
   input  wire  [pia_pkg::STATUS_W-1:0]      rsp_status,
   input  wire  [pia_pkg::CNT_W-1:0]         rsp_live_count,
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [pia_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire  [pia_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   input  wire  [pia_pkg::CSR_DATA_W-1:0]    csr_prdata,
   input  wire                               csr_pready,
   output int                                fail_count,
   output int                                open_count
);

   typedef struct packed {
      logic [pia_pkg::ID_W-1:0]     pid;
      logic [pia_pkg::STATUS_W-1:0] status;
      logic [pia_pkg::CNT_W-1:0]    live;
   } pid_outcome_type;

   // shadow of the allocator state
   logic [pia_pkg::ID_W-1:0]    shadow_ids [pia_pkg::TABLE_DEPTH];
   bit                          shadow_used [pia_pkg::TABLE_DEPTH];
   int                          live_total;
   int                          last_issued;
   int                          pid_bound;
   logic [pia_pkg::LIMIT_W-1:0] live_limit;

   pid_outcome_type expected_outcomes [$];

   initial begin
      fail_count = 0;
      open_count = 0;
   end

   function automatic void log_fault(input string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s", $realtime, msg);
   endfunction

   function automatic void check_field(input string name, input int want, input int seen);
      if (want != seen)
         log_fault($sformatf("%s mismatch: expected %0d, got %0d", name, want, seen));
   endfunction

   function automatic void clear_table();
      for (int s = 0; s < pia_pkg::TABLE_DEPTH; s++) begin
         shadow_ids[s] = '0;
         shadow_used[s] = 1'b0;
      end
      live_total = 0;
      last_issued = pia_pkg::ID_LIMIT;
      pid_bound = pia_pkg::ID_LIMIT;
      live_limit = pia_pkg::LIMIT_RESET;
   endfunction

   // walk the table from last_issued, skipping live ids and tightening the bound;
   // a collision that lands on the bound starts the walk over
   function automatic bit search_free_pid();
      int  restarts;
      bit  again;
      restarts = 0;
      pid_bound = pia_pkg::ID_LIMIT;
      while (1) begin
         again = 1'b0;
         for (int s = 0; s < pia_pkg::TABLE_DEPTH && !again; s++) begin
            if (shadow_used[s]) begin
               if (int'(shadow_ids[s]) == last_issued) begin
                  last_issued++;
                  if (last_issued >= pid_bound) begin
                     if (last_issued >= pia_pkg::ID_LIMIT)
                        last_issued = 1;
                     pid_bound = pia_pkg::ID_LIMIT;
                     again = 1'b1;
                  end
               end else if (int'(shadow_ids[s]) > last_issued &&
                            pid_bound > int'(shadow_ids[s])) begin
                  pid_bound = int'(shadow_ids[s]);
               end
            end
         end
         if (!again)
            return 1'b1;
         restarts++;
         if (restarts > 2 * pia_pkg::ID_LIMIT)
            return 1'b0;
      end
   endfunction

   function automatic pid_outcome_type apply_request(input logic kind,
                                                     input logic [pia_pkg::ID_W-1:0] id);
      pid_outcome_type r;
      bit              found;
      r.pid = '0;
      r.status = pia_pkg::STATUS_OK;
      if (kind == pia_pkg::REQ_ALLOC) begin
         if (live_total >= int'(live_limit) || live_total >= pia_pkg::TABLE_DEPTH ||
             live_total >= pia_pkg::ID_LIMIT - 1) begin
            r.status = pia_pkg::STATUS_FULL;
         end else begin
            found = 1'b1;
            last_issued++;
            if (last_issued >= pia_pkg::ID_LIMIT) begin
               last_issued = 1;
               found = search_free_pid();
            end else if (last_issued >= pid_bound) begin
               found = search_free_pid();
            end
            if (!found) begin
               r.status = pia_pkg::STATUS_FULL;
            end else begin
               for (int s = 0; s < pia_pkg::TABLE_DEPTH; s++) begin
                  if (!shadow_used[s]) begin
                     shadow_used[s] = 1'b1;
                     shadow_ids[s] = last_issued[pia_pkg::ID_W-1:0];
                     live_total++;
                     r.pid = last_issued[pia_pkg::ID_W-1:0];
                     break;
                  end
               end
            end
         end
      end else begin
         r.status = pia_pkg::STATUS_NOT_FOUND;
         for (int s = 0; s < pia_pkg::TABLE_DEPTH; s++) begin
            if (shadow_used[s] && shadow_ids[s] == id) begin
               shadow_used[s] = 1'b0;
               shadow_ids[s] = '0;
               live_total--;
               r.pid = id;
               r.status = pia_pkg::STATUS_OK;
               break;
            end
         end
      end
      r.live = live_total[pia_pkg::CNT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      pid_outcome_type want;
      if (reset) begin
         clear_table();
         expected_outcomes.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite &&
                csr_paddr[pia_pkg::CSR_ADDR_W-1:2] == pia_pkg::REG_PROCESS_LIMIT)
               live_limit = csr_pwdata[pia_pkg::LIMIT_W-1:0];
            else if (!csr_pwrite &&
                     csr_paddr[pia_pkg::CSR_ADDR_W-1:2] == pia_pkg::REG_PROCESS_LIMIT)
               check_field("process_limit readback", int'(live_limit), int'(csr_prdata));
         end
         if (req_valid && req_ready)
            expected_outcomes.push_back(apply_request(req_type, req_release_pid));
         if (rsp_valid && rsp_ready) begin
            if (expected_outcomes.size() == 0) begin
               log_fault($sformatf("result with nothing pending: pid %0d status %0d live %0d",
                                   rsp_pid, rsp_status, rsp_live_count));
            end else begin
               want = expected_outcomes.pop_front();
               check_field("pid", int'(want.pid), int'(rsp_pid));
               check_field("status", int'(want.status), int'(rsp_status));
               check_field("live_count", int'(want.live), int'(rsp_live_count));
            end
         end
      end
      open_count <= expected_outcomes.size();
   end

endmodule

// ===== verif/process_id_allocator_core_tb.sv =====
// process_id_allocator_core_tb: drives allocate/release traffic and limit changes into the
// allocator; depends on pia_pkg, process_id_allocator_core and process_id_allocator_checker
`timescale 1ns / 1ps

module process_id_allocator_core_tb;

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_type = pia_pkg::REQ_ALLOC;
   logic [pia_pkg::ID_W-1:0]       req_release_pid = '0;
   logic                           rsp_ready = 1'b0;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [pia_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [pia_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;

   wire                            req_ready;
   wire                            rsp_valid;
   wire  [pia_pkg::ID_W-1:0]       rsp_pid;
   wire  [pia_pkg::STATUS_W-1:0]   rsp_status;
   wire  [pia_pkg::CNT_W-1:0]      rsp_live_count;
   wire  [pia_pkg::CSR_DATA_W-1:0] csr_prdata;
   wire                            csr_pready;
   int                             fail_count;
   int                             open_count;

   // traffic bookkeeping
   int                             sent_count = 0;
   int                             got_count = 0;
   logic [pia_pkg::ID_W-1:0]       live_ids [$];
   bit                             source_idle = 1'b1;
   bit                             sink_idle = 1'b1;
   bit                             hold_long = 1'b0;
   logic                           rsp_seen = 1'b0;
   logic                           seen_ok = 1'b0;
   logic [pia_pkg::ID_W-1:0]       seen_pid = '0;

   localparam int PINNED = 6;

   process_id_allocator_core dut (.*);

   process_id_allocator_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin : sink_side
      int gap;
      forever begin
         @(posedge clock);
         if (hold_long) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_long = 1'b0;
            rsp_ready <= 1'b1;
         end else if (sink_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // capture results at the rising edge, update the live list at the falling edge
   always @(posedge clock) begin
      rsp_seen <= rsp_valid && rsp_ready && !reset;
      seen_pid <= rsp_pid;
      seen_ok <= (rsp_status == pia_pkg::STATUS_OK);
   end

   always @(negedge clock) begin
      int idx;
      if (rsp_seen) begin
         got_count++;
         if (seen_ok) begin
            idx = -1;
            foreach (live_ids[i])
               if (live_ids[i] == seen_pid)
                  idx = i;
            // ids are unique, so an unknown id was just allocated
            if (idx < 0)
               live_ids.push_back(seen_pid);
            else
               live_ids.delete(idx);
         end
      end
   end

   task automatic send_item(input logic kind, input logic [pia_pkg::ID_W-1:0] id);
      int gap;
      if (source_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_release_pid <= id;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (got_count != sent_count) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [pia_pkg::CSR_DATA_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= pia_pkg::CSR_ADDR_W'(pia_pkg::REG_PROCESS_LIMIT) << 2;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_limit(input int value);
      logic [pia_pkg::CSR_DATA_W-1:0] data;
      drain_results();
      // upper bits are junk, only the low bits land in the register
      data = ($urandom() & ~pia_pkg::CSR_DATA_W'(7'h7F)) | pia_pkg::CSR_DATA_W'(value);
      csr_access(1'b1, data);
      @(posedge clock);
      csr_access(1'b0, '0);
   endtask

   task automatic run_phase(input int limit_value, input int n_items, input int alloc_pct,
                            input bit idle_on, input int hold_at);
      int                       cap;
      int                       pct;
      int                       lo;
      int                       idx;
      logic [pia_pkg::ID_W-1:0] id;
      set_limit(limit_value);
      source_idle = idle_on;
      sink_idle = idle_on;
      cap = (limit_value < pia_pkg::TABLE_DEPTH) ? limit_value : pia_pkg::TABLE_DEPTH;
      for (int k = 0; k < n_items; k++) begin
         if (hold_at != 0 && k == hold_at)
            hold_long = 1'b1;
         pct = (live_ids.size() >= cap - 1) ? 30 : alloc_pct;
         if ($urandom_range(0, 9) == 0) begin
            // noise: release of an arbitrary id, live or not
            id = ($urandom_range(0, 3) == 0) ? '0 : pia_pkg::ID_W'($urandom());
            send_item(pia_pkg::REQ_RELEASE, id);
         end else if ($urandom_range(1, 100) <= pct || live_ids.size() <= PINNED) begin
            send_item(pia_pkg::REQ_ALLOC, pia_pkg::ID_W'($urandom()));
         end else begin
            // favor young ids so older ones survive and spread over the id space
            lo = PINNED;
            if ($urandom_range(0, 9) < 7 && live_ids.size() - 8 > PINNED)
               lo = live_ids.size() - 8;
            idx = $urandom_range(lo, live_ids.size() - 1);
            send_item(pia_pkg::REQ_RELEASE, live_ids[idx]);
         end
      end
   endtask

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value of the limit
      csr_access(1'b0, '0);

      // directed: empty table releases, first allocation wraps, id bit patterns
      send_item(pia_pkg::REQ_RELEASE, '0);
      send_item(pia_pkg::REQ_RELEASE, '1);
      repeat (4) send_item(pia_pkg::REQ_ALLOC, pia_pkg::ID_W'($urandom()));
      send_item(pia_pkg::REQ_RELEASE, pia_pkg::ID_W'(2));
      send_item(pia_pkg::REQ_RELEASE, pia_pkg::ID_W'(2));
      send_item(pia_pkg::REQ_ALLOC, '1);
      send_item(pia_pkg::REQ_RELEASE, 10'h2AA);
      send_item(pia_pkg::REQ_RELEASE, 10'h155);
      // zero limit refuses everything, release still works
      set_limit(0);
      send_item(pia_pkg::REQ_ALLOC, '0);
      send_item(pia_pkg::REQ_RELEASE, pia_pkg::ID_W'(1));
      send_item(pia_pkg::REQ_ALLOC, '0);
      set_limit(1);
      send_item(pia_pkg::REQ_ALLOC, '0);
      send_item(pia_pkg::REQ_RELEASE, pia_pkg::ID_W'(5));
      send_item(pia_pkg::REQ_ALLOC, '0);

      // limit above the table: fill every slot
      run_phase(127, 130, 85, 1'b1, 0);
      // churn with a long receiver hold-off in the middle
      run_phase(64, 250, 55, 1'b1, 120);
      run_phase($urandom_range(2, 63), 100, 60, 1'b0, 0);
      run_phase(1, 30, 50, 1'b1, 0);
      // long churn at the full table size
      run_phase(64, 250, 55, 1'b1, 0);
      run_phase(127, 120, 60, 1'b0, 0);

      drain_results();
      repeat (100) @(posedge clock);
      if (fail_count == 0 && open_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/pia_pkg.sv
hdl/process_id_allocator_core.sv
verif/process_id_allocator_checker.sv
verif/process_id_allocator_core_tb.sv
